### rtl/cole_pkg.sv
package cole_pkg;

	typedef enum logic [2:0] {
		CMD_APPEND     = 3'd0,
		CMD_INS_BEFORE = 3'd1,
		CMD_INS_AFTER  = 3'd2,
		CMD_TRAVERSE   = 3'd3,
		CMD_SEARCH     = 3'd4,
		CMD_DELETE     = 3'd5
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_PREV,
		RD_NEXT
	} rd_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHUP,
		S_SHUP_WR,
		S_DEL,
		S_DEL_WR,
		S_TR_RD,
		S_TR_EMIT,
		S_RESP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic      load_in;
		logic      idx_clr;
		logic      idx_inc;
		logic      idx_dec;
		logic      idx_from_cnt;
		logic      tgt_from_cnt;
		logic      tgt_from_idx;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      wr_en;
		logic      wr_shift;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      out_load;
		logic      out_entry;
		logic      out_found;
		status_t   out_status;
		logic      out_last;
	} dp_ctl_t;

	// datapath -> controller
	typedef struct packed {
		cmd_code_t cmd;
		logic      empty;
		logic      full;
		logic      match;
		logic      idx_last;
		logic      idx_gt_tgt;
		logic      out_free;
	} dp_sts_t;

endpackage

### rtl/cole_dp.sv
module cole_dp #(
	parameter int CAPACITY = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cole_pkg::dp_ctl_t     ctl,
	output cole_pkg::dp_sts_t     sts,
	input  logic [2:0]            command,
	input  logic [31:0]           new_value,
	input  logic [31:0]           key_value,
	input  logic                  res_stall,
	output logic                  res_valid,
	output logic [31:0]           entry_value,
	output logic                  found,
	output logic [1:0]            status,
	output logic                  last_of_run
);

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	logic [31:0]          mem [CAPACITY];
	logic [31:0]          rd_data_q;
	logic [31:0]          nv_q;
	logic [31:0]          key_q;
	cole_pkg::cmd_code_t  cmd_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     tgt_q;
	logic [CNT_W-1:0]     rd_ptr;
	logic [31:0]          wr_data;
	logic                 out_valid_q;
	logic [31:0]          out_entry_q;
	logic                 out_found_q;
	logic [1:0]           out_status_q;
	logic                 out_last_q;

	always_comb begin
		unique case (ctl.rd_sel)
			cole_pkg::RD_PREV: rd_ptr = idx_q - CNT_W'(1);
			cole_pkg::RD_NEXT: rd_ptr = idx_q + CNT_W'(1);
			default:           rd_ptr = idx_q;
		endcase
	end

	assign wr_data = ctl.wr_shift ? rd_data_q : nv_q;

	// single-port style store: one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[idx_q[ADDR_W-1:0]] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_ptr[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= cole_pkg::cmd_code_t'(command);
			nv_q  <= new_value;
			key_q <= key_value;
		end
		priority if (ctl.idx_clr) begin
			idx_q <= '0;
		end else if (ctl.idx_from_cnt) begin
			idx_q <= count_q;
		end else if (ctl.idx_inc) begin
			idx_q <= idx_q + CNT_W'(1);
		end else if (ctl.idx_dec) begin
			idx_q <= idx_q - CNT_W'(1);
		end else begin
			idx_q <= idx_q;
		end
		priority if (ctl.tgt_from_cnt) begin
			tgt_q <= count_q;
		end else if (ctl.tgt_from_idx) begin
			tgt_q <= idx_q + CNT_W'(cmd_q == cole_pkg::CMD_INS_AFTER);
		end else begin
			tgt_q <= tgt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.cnt_inc) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.cnt_dec) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// result register; a new result may load in the cycle the old one transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_entry_q  <= ctl.out_entry ? rd_data_q : 32'd0;
			out_found_q  <= ctl.out_found;
			out_status_q <= ctl.out_status;
			out_last_q   <= ctl.out_last;
		end
	end

	assign sts.cmd        = cmd_q;
	assign sts.empty      = (count_q == '0);
	assign sts.full       = (count_q == CNT_W'(CAPACITY));
	assign sts.match      = (rd_data_q == key_q);
	assign sts.idx_last   = ((idx_q + CNT_W'(1)) == count_q);
	assign sts.idx_gt_tgt = (idx_q > tgt_q);
	assign sts.out_free   = !out_valid_q || !res_stall;

	assign res_valid   = out_valid_q;
	assign entry_value = out_entry_q;
	assign found       = out_found_q;
	assign status      = out_status_q;
	assign last_of_run = out_last_q;

endmodule

### rtl/cole_ctrl.sv
module cole_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  cole_pkg::dp_sts_t     sts,
	output cole_pkg::dp_ctl_t     ctl
);

	cole_pkg::state_t  state_q;
	cole_pkg::state_t  state_d;
	cole_pkg::status_t res_st_q;
	cole_pkg::status_t res_st_d;
	logic              res_fnd_q;
	logic              res_fnd_d;
	logic              res_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cole_pkg::S_IDLE;
			res_st_q  <= cole_pkg::ST_OK;
			res_fnd_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_set) begin
				res_st_q  <= res_st_d;
				res_fnd_q <= res_fnd_d;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cole_pkg::S_IDLE: begin
				if (cmd_valid) state_d = cole_pkg::S_DECODE;
			end
			cole_pkg::S_DECODE: begin
				unique case (sts.cmd)
					cole_pkg::CMD_APPEND:
						state_d = sts.full ? cole_pkg::S_RESP : cole_pkg::S_SHUP;
					cole_pkg::CMD_INS_BEFORE, cole_pkg::CMD_INS_AFTER,
					cole_pkg::CMD_SEARCH, cole_pkg::CMD_DELETE:
						state_d = sts.empty ? cole_pkg::S_RESP : cole_pkg::S_SRCH_RD;
					cole_pkg::CMD_TRAVERSE:
						state_d = sts.empty ? cole_pkg::S_RESP : cole_pkg::S_TR_RD;
					default:
						state_d = cole_pkg::S_IDLE;
				endcase
			end
			cole_pkg::S_SRCH_RD: state_d = cole_pkg::S_SRCH_CMP;
			cole_pkg::S_SRCH_CMP: begin
				if (sts.match) begin
					priority if (sts.cmd == cole_pkg::CMD_SEARCH) begin
						state_d = cole_pkg::S_RESP;
					end else if (sts.cmd == cole_pkg::CMD_DELETE) begin
						state_d = cole_pkg::S_DEL;
					end else if (sts.full) begin
						state_d = cole_pkg::S_RESP;
					end else begin
						state_d = cole_pkg::S_SHUP;
					end
				end else if (sts.idx_last) begin
					state_d = cole_pkg::S_RESP;
				end else begin
					state_d = cole_pkg::S_SRCH_RD;
				end
			end
			cole_pkg::S_SHUP:
				state_d = sts.idx_gt_tgt ? cole_pkg::S_SHUP_WR : cole_pkg::S_RESP;
			cole_pkg::S_SHUP_WR: state_d = cole_pkg::S_SHUP;
			cole_pkg::S_DEL:
				state_d = sts.idx_last ? cole_pkg::S_RESP : cole_pkg::S_DEL_WR;
			cole_pkg::S_DEL_WR: state_d = cole_pkg::S_DEL;
			cole_pkg::S_TR_RD: state_d = cole_pkg::S_TR_EMIT;
			cole_pkg::S_TR_EMIT: begin
				if (sts.out_free) begin
					state_d = sts.idx_last ? cole_pkg::S_IDLE : cole_pkg::S_TR_RD;
				end
			end
			cole_pkg::S_RESP: begin
				if (sts.out_free) state_d = cole_pkg::S_IDLE;
			end
			default: state_d = cole_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl            = '0;
		ctl.rd_sel     = cole_pkg::RD_IDX;
		ctl.out_status = cole_pkg::ST_OK;
		res_set        = 1'b0;
		res_st_d       = cole_pkg::ST_OK;
		res_fnd_d      = 1'b0;
		cmd_stall      = (state_q != cole_pkg::S_IDLE);
		unique case (state_q)
			cole_pkg::S_IDLE: begin
				ctl.load_in = cmd_valid;
			end
			cole_pkg::S_DECODE: begin
				res_set = 1'b1;
				unique case (sts.cmd)
					cole_pkg::CMD_APPEND: begin
						res_st_d = sts.full ? cole_pkg::ST_FULL : cole_pkg::ST_OK;
						ctl.idx_from_cnt = 1'b1;
						ctl.tgt_from_cnt = 1'b1;
					end
					cole_pkg::CMD_INS_BEFORE, cole_pkg::CMD_INS_AFTER,
					cole_pkg::CMD_SEARCH, cole_pkg::CMD_DELETE,
					cole_pkg::CMD_TRAVERSE: begin
						res_st_d = cole_pkg::ST_EMPTY;
						ctl.idx_clr = 1'b1;
					end
					default: begin
						res_set = 1'b0;
					end
				endcase
			end
			cole_pkg::S_SRCH_RD: begin
				ctl.rd_en = 1'b1;
			end
			cole_pkg::S_SRCH_CMP: begin
				res_set = 1'b1;
				if (sts.match) begin
					res_fnd_d = 1'b1;
					priority if (sts.cmd == cole_pkg::CMD_SEARCH ||
					             sts.cmd == cole_pkg::CMD_DELETE) begin
						res_st_d = cole_pkg::ST_OK;
					end else if (sts.full) begin
						res_st_d = cole_pkg::ST_FULL;
					end else begin
						// insert point fixed, start shifting from the tail
						res_st_d         = cole_pkg::ST_OK;
						ctl.tgt_from_idx = 1'b1;
						ctl.idx_from_cnt = 1'b1;
					end
				end else begin
					res_st_d    = cole_pkg::ST_NOTFOUND;
					ctl.idx_inc = !sts.idx_last;
				end
			end
			cole_pkg::S_SHUP: begin
				if (sts.idx_gt_tgt) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = cole_pkg::RD_PREV;
				end else begin
					ctl.wr_en   = 1'b1;
					ctl.cnt_inc = 1'b1;
				end
			end
			cole_pkg::S_SHUP_WR: begin
				ctl.wr_en    = 1'b1;
				ctl.wr_shift = 1'b1;
				ctl.idx_dec  = 1'b1;
			end
			cole_pkg::S_DEL: begin
				if (sts.idx_last) begin
					ctl.cnt_dec = 1'b1;
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = cole_pkg::RD_NEXT;
				end
			end
			cole_pkg::S_DEL_WR: begin
				ctl.wr_en    = 1'b1;
				ctl.wr_shift = 1'b1;
				ctl.idx_inc  = 1'b1;
			end
			cole_pkg::S_TR_RD: begin
				ctl.rd_en = 1'b1;
			end
			cole_pkg::S_TR_EMIT: begin
				if (sts.out_free) begin
					ctl.out_load  = 1'b1;
					ctl.out_entry = 1'b1;
					ctl.out_last  = sts.idx_last;
					ctl.idx_inc   = !sts.idx_last;
				end
			end
			cole_pkg::S_RESP: begin
				ctl.out_load   = sts.out_free;
				ctl.out_found  = res_fnd_q;
				ctl.out_status = res_st_q;
				ctl.out_last   = 1'b1;
			end
			default: begin
				ctl.load_in = 1'b0;
			end
		endcase
	end

endmodule

### rtl/circular_ordered_list_engine_top.sv
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+-----------------------------------------------
// command  | cmd_valid | cmd_stall | command, new_value, key_value
// result   | res_valid | res_stall | entry_value, found, status, last_of_run
//
// One command at a time. A command is accepted in the idle state and then decoded; each
// entry compared, moved or emitted first needs a read of the entry store, which has a
// single access per cycle with a registered read. The longest commands, from one
// command transfer to the next, are an insert before the head of a list one short of
// full, or a delete of the head of a full list.
// Reset clears the entry count and result valid; store contents are never read
// before written. A stalled result holds; the next command is taken meanwhile.
module circular_ordered_list_engine_top #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [2:0]         command,
	input  logic signed [31:0] new_value,
	input  logic signed [31:0] key_value,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] entry_value,
	output logic               found,
	output logic [1:0]         status,
	output logic               last_of_run
);

	cole_pkg::dp_ctl_t ctl;
	cole_pkg::dp_sts_t sts;
	logic [31:0]       entry_raw;

	cole_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	cole_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.command     (command),
		.new_value   (new_value),
		.key_value   (key_value),
		.res_stall   (res_stall),
		.res_valid   (res_valid),
		.entry_value (entry_raw),
		.found       (found),
		.status      (status),
		.last_of_run (last_of_run)
	);

	assign entry_value = entry_raw;

endmodule
